// ----- hw/rtl/aldc_pkg.sv -----
// Package: types, codes and constants of the list download client.
`timescale 1ns / 1ps
`default_nettype none
package aldc_pkg;

	localparam int unsigned CmdW   = 3;
	localparam int unsigned KindW  = 3;
	localparam int unsigned CodeW  = 2;
	localparam int unsigned SeqW   = 16;
	localparam int unsigned LimitW = 4;
	localparam int unsigned RetryW = 5;

	localparam logic [LimitW-1:0] RETRY_LIMIT_RESET = LimitW'(3);
	localparam logic [RetryW-1:0] RETRY_MAX         = {RetryW{1'b1}};

	typedef enum logic [CmdW-1:0] {
		CMD_START  = 3'd0,
		CMD_COUNT  = 3'd1,
		CMD_ITEM   = 3'd2,
		CMD_TICK   = 3'd3,
		CMD_CANCEL = 3'd4
	} cmd_t;

	typedef enum logic [KindW-1:0] {
		KIND_NONE                 = 3'd0,
		KIND_LIST                 = 3'd1,
		KIND_READ                 = 3'd2,
		KIND_CHECK_LIST_ACCEPTED  = 3'd3,
		KIND_CHECK_LIST_CANCELLED = 3'd4
	} kind_t;

	typedef enum logic [CodeW-1:0] {
		RES_OK      = 2'd0,
		RES_CONN    = 2'd1,
		RES_TIMEOUT = 2'd2,
		RES_CANCEL  = 2'd3
	} code_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LIST = 2'd1,
		PH_ITEM = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CmdW-1:0] command;
		logic [SeqW-1:0] count_value;
		logic [SeqW-1:0] item_index;
		logic            send_accepted;
	} in_word_t;

	typedef struct packed {
		logic [KindW-1:0] send_kind;
		logic [SeqW-1:0]  send_sequence;
		logic             item_stored;
		logic [SeqW-1:0]  stored_index;
		logic             finished;
		logic [CodeW-1:0] result_code;
	} out_word_t;

	typedef struct packed {
		phase_t            phase;
		logic [RetryW-1:0] retries_done;
		logic [SeqW-1:0]   next_sequence;
		logic [SeqW-1:0]   expected_count;
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/aldc_channels.sv -----
// Interfaces: event, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface aldc_in_if;
	logic                          valid;
	logic                          ready;
	logic [aldc_pkg::CmdW-1:0]     command;
	logic [aldc_pkg::SeqW-1:0]     count_value;
	logic [aldc_pkg::SeqW-1:0]     item_index;
	logic                          send_accepted;

	modport source (output valid, command, count_value, item_index, send_accepted,
		input ready);
	modport sink (input valid, command, count_value, item_index, send_accepted,
		output ready);
endinterface

interface aldc_out_if;
	logic                          valid;
	logic                          ready;
	logic [aldc_pkg::KindW-1:0]    send_kind;
	logic [aldc_pkg::SeqW-1:0]     send_sequence;
	logic                          item_stored;
	logic [aldc_pkg::SeqW-1:0]     stored_index;
	logic                          finished;
	logic [aldc_pkg::CodeW-1:0]    result_code;

	modport source (output valid, send_kind, send_sequence, item_stored, stored_index,
		finished, result_code, input ready);
	modport sink (input valid, send_kind, send_sequence, item_stored, stored_index,
		finished, result_code, output ready);
endinterface

interface aldc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [aldc_pkg::LimitW-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/aldc_step.sv -----
// Step logic: next protocol state and result word for one event.
`timescale 1ns / 1ps
`default_nettype none
module aldc_step (
	input  aldc_pkg::in_word_t            in_word,
	input  aldc_pkg::state_t              cur,
	input  logic [aldc_pkg::LimitW-1:0]   retry_limit,
	output aldc_pkg::state_t              nxt,
	output aldc_pkg::out_word_t           res
);

	aldc_pkg::phase_t   phase_eff;
	logic               do_req;
	aldc_pkg::kind_t    req_kind;
	logic               do_ack;
	aldc_pkg::kind_t    ack_kind;
	aldc_pkg::code_t    ack_code;
	logic               do_fin;
	aldc_pkg::code_t    fin_code;
	logic               last_item;
	logic               ok;

	assign ok = in_word.send_accepted;
	assign last_item = ({1'b0, cur.next_sequence} + 17'd1) == {1'b0, cur.expected_count};

	always_comb begin
		case (cur.phase)
			aldc_pkg::PH_LIST: phase_eff = aldc_pkg::PH_LIST;
			aldc_pkg::PH_ITEM: phase_eff = aldc_pkg::PH_ITEM;
			default:           phase_eff = aldc_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		nxt       = cur;
		nxt.phase = phase_eff;
		res       = '0;
		do_req    = 1'b0;
		req_kind  = aldc_pkg::KIND_NONE;
		do_ack    = 1'b0;
		ack_kind  = aldc_pkg::KIND_NONE;
		ack_code  = aldc_pkg::RES_OK;
		do_fin    = 1'b0;
		fin_code  = aldc_pkg::RES_OK;

		case (aldc_pkg::cmd_t'(in_word.command))
			aldc_pkg::CMD_START: begin
				nxt.phase        = aldc_pkg::PH_LIST;
				nxt.retries_done = '0;
				do_req           = 1'b1;
				req_kind         = aldc_pkg::KIND_LIST;
			end
			aldc_pkg::CMD_COUNT: begin
				if (phase_eff != aldc_pkg::PH_IDLE) begin
					if (in_word.count_value == '0) begin
						do_ack   = 1'b1;
						ack_kind = aldc_pkg::KIND_CHECK_LIST_ACCEPTED;
						ack_code = aldc_pkg::RES_OK;
					end else begin
						nxt.next_sequence  = '0;
						nxt.phase          = aldc_pkg::PH_ITEM;
						nxt.retries_done   = '0;
						nxt.expected_count = in_word.count_value;
						do_req             = 1'b1;
						req_kind           = aldc_pkg::KIND_READ;
					end
				end
			end
			aldc_pkg::CMD_ITEM: begin
				if (phase_eff == aldc_pkg::PH_ITEM) begin
					res.item_stored  = 1'b1;
					res.stored_index = in_word.item_index;
					if (last_item) begin
						do_ack   = 1'b1;
						ack_kind = aldc_pkg::KIND_CHECK_LIST_ACCEPTED;
						ack_code = aldc_pkg::RES_OK;
					end else begin
						// index wraps to zero after the top value
						nxt.next_sequence = in_word.item_index + aldc_pkg::SeqW'(1);
						nxt.retries_done  = '0;
						do_req            = 1'b1;
						req_kind          = aldc_pkg::KIND_READ;
					end
				end
			end
			aldc_pkg::CMD_TICK: begin
				if (phase_eff != aldc_pkg::PH_IDLE) begin
					if (cur.retries_done >= {1'b0, retry_limit}) begin
						do_fin   = 1'b1;
						fin_code = aldc_pkg::RES_TIMEOUT;
					end else begin
						do_req   = 1'b1;
						req_kind = (phase_eff == aldc_pkg::PH_LIST) ? aldc_pkg::KIND_LIST
							: aldc_pkg::KIND_READ;
					end
				end
			end
			aldc_pkg::CMD_CANCEL: begin
				if (phase_eff != aldc_pkg::PH_IDLE) begin
					do_ack   = 1'b1;
					ack_kind = aldc_pkg::KIND_CHECK_LIST_CANCELLED;
					ack_code = aldc_pkg::RES_CANCEL;
				end
			end
			default: begin
			end
		endcase

		if (do_req) begin
			res.send_kind = req_kind;
			if (req_kind == aldc_pkg::KIND_READ) begin
				res.send_sequence = nxt.next_sequence;
			end
			if (!ok) begin
				do_fin   = 1'b1;
				fin_code = aldc_pkg::RES_CONN;
			end else if (nxt.retries_done != aldc_pkg::RETRY_MAX) begin
				nxt.retries_done = nxt.retries_done + aldc_pkg::RetryW'(1);
			end
		end

		if (do_ack) begin
			res.send_kind = ack_kind;
			do_fin        = 1'b1;
			fin_code      = ok ? ack_code : aldc_pkg::RES_CONN;
		end

		if (do_fin) begin
			res.finished    = 1'b1;
			res.result_code = fin_code;
			nxt.phase       = aldc_pkg::PH_IDLE;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/alarm_list_download_client_unit.sv -----
// Top level: list download client with input and result registers.
// Result path: an accepted event is held in the input reg, then its result word in the result reg.
// Throughput: one event per cycle unless out_ch stalls; the step logic sits between the two registers.
// Input ready drops only while both the input reg and a stalled result reg are full.
// Reset: asynchronous, clears valids, phase to idle, counters to zero, retry_limit to 3.
`timescale 1ns / 1ps
`default_nettype none
module alarm_list_download_client_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	aldc_in_if.sink       in_ch,
	aldc_out_if.source    out_ch,
	aldc_cfg_if.sink      cfg_ch
);

	aldc_pkg::in_word_t            in_s1;
	logic                          valid_s1;
	aldc_pkg::state_t              state_q;
	aldc_pkg::state_t              state_nxt;
	aldc_pkg::out_word_t           res_nxt;
	aldc_pkg::out_word_t           out_s2;
	logic                          valid_s2;
	logic [aldc_pkg::LimitW-1:0]   retry_limit_q;
	logic                          adv_s1;
	logic                          take_in;

	assign adv_s1  = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign take_in = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= aldc_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_ch.valid) begin
			retry_limit_q <= cfg_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			in_s1.command       <= in_ch.command;
			in_s1.count_value   <= in_ch.count_value;
			in_s1.item_index    <= in_ch.item_index;
			in_s1.send_accepted <= in_ch.send_accepted;
		end
	end

	aldc_step u_step (
		.in_word     (in_s1),
		.cur         (state_q),
		.retry_limit (retry_limit_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= aldc_pkg::PH_IDLE;
			state_q.retries_done   <= '0;
			state_q.next_sequence  <= '0;
			state_q.expected_count <= '0;
			valid_s2               <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_s2 <= res_nxt;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.send_kind     = out_s2.send_kind;
	assign out_ch.send_sequence = out_s2.send_sequence;
	assign out_ch.item_stored   = out_s2.item_stored;
	assign out_ch.stored_index  = out_s2.stored_index;
	assign out_ch.finished      = out_s2.finished;
	assign out_ch.result_code   = out_s2.result_code;

endmodule
`default_nettype wire

// ----- hw/rtl/aldc_checker.sv -----
// Checker: port-level assertions on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module aldc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [aldc_pkg::KindW-1:0]    send_kind,
	input wire logic [aldc_pkg::SeqW-1:0]     send_sequence,
	input wire logic                          item_stored,
	input wire logic [aldc_pkg::SeqW-1:0]     stored_index,
	input wire logic                          finished,
	input wire logic [aldc_pkg::CodeW-1:0]    result_code
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(send_kind)
			&& $stable(send_sequence) && $stable(finished) && $stable(result_code))
		else $error("result word changed while stalled");

	a_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> result_code == aldc_pkg::RES_OK)
		else $error("result code set without finish");

	a_seq_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_kind != aldc_pkg::KIND_READ |-> send_sequence == '0)
		else $error("sequence set on a non-read word");

	a_cancel_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_kind == aldc_pkg::KIND_CHECK_LIST_CANCELLED
			|-> finished && (result_code == aldc_pkg::RES_CANCEL
				|| result_code == aldc_pkg::RES_CONN)
			&& !item_stored && stored_index == '0)
		else $error("cancel ack with wrong status");

endmodule

bind alarm_list_download_client_unit aldc_checker u_aldc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.send_kind     (out_ch.send_kind),
	.send_sequence (out_ch.send_sequence),
	.item_stored   (out_ch.item_stored),
	.stored_index  (out_ch.stored_index),
	.finished      (out_ch.finished),
	.result_code   (out_ch.result_code)
);
`default_nettype wire
